FILE: rtl/fctd_pkg.sv
`timescale 1ns / 1ps
// Package: shared constants, types and helpers of the fault counter table.
package fctd_pkg;

	// Default sizing of the table
	localparam int NUM_GROUPS_DEF    = 11;
	localparam int TOTAL_ENTRIES_DEF = 64;
	localparam int DUMP_DEPTH_DEF    = 32;

	// Field widths
	localparam int SIZE_W      = 5;
	localparam int SIZE_GROUPS = 11;
	localparam int SIZES_W     = SIZE_GROUPS * SIZE_W;
	localparam int GROUP_W     = 4;
	localparam int INST_W      = 5;
	localparam int SLOT_W      = 5;
	localparam int MODE_W      = 2;
	localparam int STATUS_W    = 2;
	localparam int CNT_W       = 8;
	localparam int TOTAL_W     = 7;
	localparam int BASE_W      = 9;
	localparam int DUMP_W      = GROUP_W + INST_W;

	// Configuration port
	localparam int APB_DW = 64;
	localparam int APB_AW = 4;
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_SIZES     = 1'b1;
	localparam logic [CNT_W-1:0] THR_RESET = 8'd3;

	typedef enum logic [MODE_W-1:0] {
		MODE_SET  = 2'd0,
		MODE_CLR  = 2'd1,
		MODE_SCAN = 2'd2,
		MODE_READ = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_EMPTY   = 2'd2
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic pfx_clr;
		logic pfx_step;
		logic scan_clr;
		logic scan_rd;
		logic finish;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic total_zero;
		logic limit_zero;
		logic scan_last;
		logic pfx_last;
	} stat_t;

	// Instance count of one group; groups past the packed word hold none
	function automatic logic [SIZE_W-1:0] size_of(input logic [SIZES_W-1:0] sizes,
			input logic [GROUP_W-1:0] g);
		logic [SIZE_W-1:0] s;
		s = '0;
		for (int i = 0; i < SIZE_GROUPS; i++) begin
			if (g == GROUP_W'(i)) begin
				s = sizes[i*SIZE_W +: SIZE_W];
			end
		end
		return s;
	endfunction

endpackage

FILE: rtl/fault_counter_table_with_expiry_dump.sv
`timescale 1ns / 1ps
// Top level: fault counter table with sticky expiry scan and dump readout.
//
//  channel   handshake                          payload
//  --------  ---------------------------------  ------------------------------------------
//  request   start & !busy                      mode, group, instance_req, dump_slot
//  result    done (one cycle, no backpressure)  status, expired_count, dump_group,
//                                               dump_instance
//  config    psel & penable & pwrite (pready)   paddr, pwdata, prdata
//
// Increment, clear, dump read and a scan that finds earlier faults go from accept
// to the next accept through one counter or dump memory read, then the write back
// and result register. A full scan reads the counter memory once per entry, for
// min(sum of sizes, table size) entries, then drains and finishes. A write of
// group_sizes holds busy while the new layout is picked up and then the group base
// adder rebuilds the prefix sums one group at a time. Reset is asynchronous;
// counters read as zero until written, through per-entry valid bits. The result
// has no ready and is never held.
module fault_counter_table_with_expiry_dump #(
	parameter int NUM_GROUPS    = fctd_pkg::NUM_GROUPS_DEF,
	parameter int TOTAL_ENTRIES = fctd_pkg::TOTAL_ENTRIES_DEF,
	parameter int DUMP_DEPTH    = fctd_pkg::DUMP_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request
	input  logic                          start,
	output logic                          busy,
	input  logic [fctd_pkg::MODE_W-1:0]   mode,
	input  logic [fctd_pkg::GROUP_W-1:0]  group,
	input  logic [fctd_pkg::INST_W-1:0]   instance_req,
	input  logic [fctd_pkg::SLOT_W-1:0]   dump_slot,
	// result
	output logic                          done,
	output logic [fctd_pkg::STATUS_W-1:0] status,
	output logic [fctd_pkg::TOTAL_W-1:0]  expired_count,
	output logic [fctd_pkg::GROUP_W-1:0]  dump_group,
	output logic [fctd_pkg::INST_W-1:0]   dump_instance,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fctd_pkg::APB_AW-1:0]   paddr,
	input  logic [fctd_pkg::APB_DW-1:0]   pwdata,
	output logic [fctd_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import fctd_pkg::*;

	logic [CNT_W-1:0]   threshold;
	logic [SIZES_W-1:0] group_sizes;
	logic               sizes_new;
	cmd_t               cmd;
	stat_t              stat;

	// configuration registers
	fctd_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.threshold   (threshold),
		.group_sizes (group_sizes),
		.sizes_new   (sizes_new)
	);

	// sequencing
	fctd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.sizes_new (sizes_new),
		.stat      (stat),
		.busy      (busy),
		.done      (done),
		.cmd       (cmd)
	);

	// storage and arithmetic
	fctd_dp #(
		.NUM_GROUPS    (NUM_GROUPS),
		.TOTAL_ENTRIES (TOTAL_ENTRIES),
		.DUMP_DEPTH    (DUMP_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.mode          (mode),
		.group         (group),
		.instance_req  (instance_req),
		.dump_slot     (dump_slot),
		.threshold     (threshold),
		.group_sizes   (group_sizes),
		.stat          (stat),
		.status        (status),
		.expired_count (expired_count),
		.dump_group    (dump_group),
		.dump_instance (dump_instance)
	);

endmodule

FILE: rtl/fctd_regs.sv
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port.
module fctd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fctd_pkg::APB_AW-1:0]   paddr,
	input  logic [fctd_pkg::APB_DW-1:0]   pwdata,
	output logic [fctd_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output logic [fctd_pkg::CNT_W-1:0]    threshold,
	output logic [fctd_pkg::SIZES_W-1:0]  group_sizes,
	output logic                          sizes_new
);
	import fctd_pkg::*;

	logic               wr_en;
	logic               reg_sel;
	logic [CNT_W-1:0]   thr_q;
	logic [SIZES_W-1:0] sizes_q;
	logic               sizes_new_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	// registers sit 8 bytes apart
	assign reg_sel = paddr[APB_AW-1];

	// register write; a new group layout flags the prefix rebuild
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_RESET;
			sizes_q     <= '0;
			sizes_new_q <= 1'b0;
		end else begin
			sizes_new_q <= 1'b0;
			if (wr_en) begin
				unique case (reg_sel)
					REG_THRESHOLD: thr_q <= pwdata[CNT_W-1:0];
					REG_SIZES: begin
						sizes_q     <= pwdata[SIZES_W-1:0];
						sizes_new_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// read back
	always_comb begin
		unique case (reg_sel)
			REG_THRESHOLD: prdata = APB_DW'(thr_q);
			REG_SIZES:     prdata = APB_DW'(sizes_q);
			default:       prdata = '0;
		endcase
	end

	assign threshold   = thr_q;
	assign group_sizes = sizes_q;
	assign sizes_new   = sizes_new_q;

endmodule

FILE: rtl/fctd_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences requests, scans and prefix rebuilds.
module fctd_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fctd_pkg::MODE_W-1:0]   mode,
	input  logic                          sizes_new,
	input  fctd_pkg::stat_t               stat,
	output logic                          busy,
	output logic                          done,
	output fctd_pkg::cmd_t                cmd
);
	import fctd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PFX,
		S_SCAN,
		S_DRAIN,
		S_FIN
	} state_t;

	state_t state_q;
	logic   done_q;
	logic   scan_go;

	assign busy = (state_q != S_IDLE) | sizes_new;

	// a scan walks the table only when nothing has been recorded yet
	assign scan_go = (mode_t'(mode) == MODE_SCAN) & stat.total_zero & ~stat.limit_zero;

	// commands per state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (sizes_new) begin
					cmd.pfx_clr = 1'b1;
				end else if (start) begin
					cmd.load     = 1'b1;
					cmd.scan_clr = scan_go;
				end
			end
			S_PFX:   cmd.pfx_step = 1'b1;
			S_SCAN:  cmd.scan_rd  = 1'b1;
			S_DRAIN: ;
			S_FIN:   cmd.finish   = 1'b1;
			default: ;
		endcase
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_FIN);
			unique case (state_q)
				S_IDLE: begin
					if (sizes_new) begin
						state_q <= S_PFX;
					end else if (start) begin
						state_q <= scan_go ? S_SCAN : S_FIN;
					end
				end
				S_PFX: begin
					if (stat.pfx_last) state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (stat.scan_last) state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_FIN;
				S_FIN:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = done_q;

endmodule

FILE: rtl/fctd_dp.sv
`timescale 1ns / 1ps
// Datapath: group prefix sums, counter memory, scan stage and expiry dump.
module fctd_dp #(
	parameter int NUM_GROUPS    = fctd_pkg::NUM_GROUPS_DEF,
	parameter int TOTAL_ENTRIES = fctd_pkg::TOTAL_ENTRIES_DEF,
	parameter int DUMP_DEPTH    = fctd_pkg::DUMP_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fctd_pkg::cmd_t                cmd,
	input  logic [fctd_pkg::MODE_W-1:0]   mode,
	input  logic [fctd_pkg::GROUP_W-1:0]  group,
	input  logic [fctd_pkg::INST_W-1:0]   instance_req,
	input  logic [fctd_pkg::SLOT_W-1:0]   dump_slot,
	input  logic [fctd_pkg::CNT_W-1:0]    threshold,
	input  logic [fctd_pkg::SIZES_W-1:0]  group_sizes,
	output fctd_pkg::stat_t               stat,
	output logic [fctd_pkg::STATUS_W-1:0] status,
	output logic [fctd_pkg::TOTAL_W-1:0]  expired_count,
	output logic [fctd_pkg::GROUP_W-1:0]  dump_group,
	output logic [fctd_pkg::INST_W-1:0]   dump_instance
);
	import fctd_pkg::*;

	localparam int AW    = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;
	localparam int DAW   = (DUMP_DEPTH > 1) ? $clog2(DUMP_DEPTH) : 1;
	localparam int PW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int IDX_W = BASE_W + 1;

	// prefix sums: base_q[g] is the first flat index of group g
	logic [BASE_W-1:0]  base_q [NUM_GROUPS+1];
	logic [PW-1:0]      pfx_q;

	// request decode
	logic [BASE_W-1:0]  req_base;
	logic [SIZE_W-1:0]  req_size;
	logic [IDX_W-1:0]   req_idx;
	logic               req_bad;

	// latched request
	mode_t              mode_q;
	logic               bad_q;
	logic [AW-1:0]      idx_q;
	logic [SLOT_W-1:0]  slot_q;

	// scan walk
	logic [BASE_W-1:0]  limit;
	logic [AW-1:0]      scan_q;
	logic               chk_s1;
	logic [AW-1:0]      sidx_s1;
	logic [GROUP_W-1:0] hit_grp;
	logic [BASE_W-1:0]  hit_base;
	logic [BASE_W-1:0]  hit_off;
	logic               hit;
	logic [TOTAL_W-1:0] total_q;

	// counter memory
	logic [CNT_W-1:0]         cnt_mem [TOTAL_ENTRIES];
	logic [TOTAL_ENTRIES-1:0] cnt_vld_q;
	logic [AW-1:0]            rd_addr;
	logic [CNT_W-1:0]         cnt_rd_s1;
	logic                     cnt_vld_s1;
	logic [CNT_W-1:0]         cnt_cur;
	logic                     cnt_we;
	logic [CNT_W-1:0]         cnt_wdata;

	// expiry dump
	logic [DUMP_W-1:0]  dump_mem [DUMP_DEPTH];
	logic [DUMP_W-1:0]  dump_rd_s1;
	logic               dump_we;
	logic               slot_ok;

	// result
	status_t            res_status_q;
	logic [TOTAL_W-1:0] res_count_q;
	logic [GROUP_W-1:0] res_grp_q;
	logic [INST_W-1:0]  res_inst_q;

	// prefix rebuild, one group per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfx_q <= '0;
			for (int g = 0; g <= NUM_GROUPS; g++) begin
				base_q[g] <= '0;
			end
		end else begin
			if (cmd.pfx_clr) begin
				pfx_q <= '0;
			end else if (cmd.pfx_step) begin
				pfx_q <= pfx_q + 1'b1;
			end
			if (cmd.pfx_step) begin
				for (int g = 0; g < NUM_GROUPS; g++) begin
					if (pfx_q == PW'(g)) begin
						base_q[g+1] <= base_q[g]
							+ BASE_W'(size_of(group_sizes, GROUP_W'(g)));
					end
				end
			end
		end
	end

	assign stat.pfx_last = (pfx_q == PW'(NUM_GROUPS - 1));

	// flat index of the requested pair
	always_comb begin
		req_base = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (group == GROUP_W'(g)) req_base = base_q[g];
		end
	end

	assign req_size = size_of(group_sizes, group);
	assign req_idx  = IDX_W'(req_base) + IDX_W'(instance_req);
	assign req_bad  = (group >= GROUP_W'(NUM_GROUPS))
		| (instance_req >= req_size)
		| (req_idx >= IDX_W'(TOTAL_ENTRIES));

	// latch the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode_t'(mode);
			bad_q  <= req_bad;
			idx_q  <= req_idx[AW-1:0];
			slot_q <= dump_slot;
		end
	end

	// scan limit and walk index
	assign limit = (base_q[NUM_GROUPS] > BASE_W'(TOTAL_ENTRIES))
		? BASE_W'(TOTAL_ENTRIES) : base_q[NUM_GROUPS];
	assign stat.limit_zero = (limit == '0);
	assign stat.scan_last  = (BASE_W'(scan_q) == limit - 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.scan_clr) begin
			scan_q <= '0;
		end else if (cmd.scan_rd) begin
			scan_q <= scan_q + 1'b1;
		end
	end

	// counter memory: read every cycle, write back on finish
	assign rd_addr = cmd.scan_rd ? scan_q : req_idx[AW-1:0];

	always_ff @(posedge clk) begin
		cnt_rd_s1 <= cnt_mem[rd_addr];
		if (cnt_we) cnt_mem[idx_q] <= cnt_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q  <= '0;
			cnt_vld_s1 <= 1'b0;
			chk_s1     <= 1'b0;
		end else begin
			cnt_vld_s1 <= cnt_vld_q[rd_addr];
			chk_s1     <= cmd.scan_rd;
			if (cnt_we) cnt_vld_q[idx_q] <= 1'b1;
		end
	end

	// a never-written counter reads as zero
	assign cnt_cur = cnt_vld_s1 ? cnt_rd_s1 : '0;

	// increment saturates, clear zeroes
	assign cnt_we = cmd.finish & ~bad_q & ((mode_q == MODE_SET) | (mode_q == MODE_CLR));
	always_comb begin
		if (mode_q == MODE_SET) begin
			cnt_wdata = (cnt_cur == '1) ? cnt_cur : cnt_cur + 1'b1;
		end else begin
			cnt_wdata = '0;
		end
	end

	// scan check stage: decode index into (group, instance)
	always_ff @(posedge clk) begin
		sidx_s1 <= scan_q;
	end

	// last group whose base is at or below the index owns it
	always_comb begin
		hit_grp  = '0;
		hit_base = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (base_q[g] <= BASE_W'(sidx_s1)) begin
				hit_grp  = GROUP_W'(g);
				hit_base = base_q[g];
			end
		end
	end

	assign hit_off = BASE_W'(sidx_s1) - hit_base;
	assign hit     = chk_s1 & (cnt_cur >= threshold);
	assign dump_we = hit & (total_q < TOTAL_W'(DUMP_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (hit) begin
			total_q <= total_q + 1'b1;
		end
	end

	assign stat.total_zero = (total_q == '0);

	// dump memory
	always_ff @(posedge clk) begin
		dump_rd_s1 <= dump_mem[dump_slot[DAW-1:0]];
		if (dump_we) dump_mem[total_q[DAW-1:0]] <= {hit_grp, hit_off[INST_W-1:0]};
	end

	assign slot_ok = (TOTAL_W'(slot_q) < total_q) & (TOTAL_W'(slot_q) < TOTAL_W'(DUMP_DEPTH));

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_status_q <= ST_OK;
			res_count_q  <= total_q;
			res_grp_q    <= '0;
			res_inst_q   <= '0;
			case (mode_q) inside
				MODE_SET, MODE_CLR: begin
					if (bad_q) res_status_q <= ST_INVALID;
				end
				MODE_READ: begin
					if (slot_ok) begin
						res_grp_q  <= dump_rd_s1[DUMP_W-1:INST_W];
						res_inst_q <= dump_rd_s1[INST_W-1:0];
					end else begin
						res_status_q <= ST_EMPTY;
					end
				end
				default: ;
			endcase
		end
	end

	assign status        = res_status_q;
	assign expired_count = res_count_q;
	assign dump_group    = res_grp_q;
	assign dump_instance = res_inst_q;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench: fault counter table with expiry dump, checked against a local model.
module tb;
	import fctd_pkg::*;

	localparam int NGROUPS   = NUM_GROUPS_DEF;
	localparam int NENTRIES  = TOTAL_ENTRIES_DEF;
	localparam int NDUMP     = DUMP_DEPTH_DEF;
	localparam int RUN_LIMIT = 500000;
	localparam int DRAIN     = 80;
	localparam logic [APB_AW-1:0] THR_ADDR   = APB_AW'(8 * REG_THRESHOLD);
	localparam logic [APB_AW-1:0] SIZES_ADDR = APB_AW'(8 * REG_SIZES);
	localparam logic [APB_DW-1:0] SIZES_FULL = {{(APB_DW-SIZES_W){1'b0}}, {SIZES_W{1'b1}}};
	// groups 0 and 1 full, group 2 two wide: exactly fills the table
	localparam logic [APB_DW-1:0] SIZES_EXACT = 64'h0BFF;

	typedef struct packed {
		mode_t              md;
		logic [GROUP_W-1:0] grp;
		logic [INST_W-1:0]  inst;
		logic [SLOT_W-1:0]  slot;
	} request_t;

	typedef struct packed {
		status_t            st;
		logic [TOTAL_W-1:0] cnt;
		logic [GROUP_W-1:0] grp;
		logic [INST_W-1:0]  inst;
	} outcome_t;

	typedef enum logic [1:0] {
		STEP_REQ,
		STEP_THR,
		STEP_SIZES
	} step_kind_t;

	typedef struct {
		step_kind_t        kind;
		request_t          req;
		logic [APB_DW-1:0] value;
		bit                typed;
		outcome_t          want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [MODE_W-1:0] mode = '0;
	logic [GROUP_W-1:0] group = '0;
	logic [INST_W-1:0] instance_req = '0;
	logic [SLOT_W-1:0] dump_slot = '0;
	logic done;
	logic [STATUS_W-1:0] status;
	logic [TOTAL_W-1:0] expired_count;
	logic [GROUP_W-1:0] dump_group;
	logic [INST_W-1:0] dump_instance;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	// Local copy of the table state
	logic [CNT_W-1:0]   thr_m;
	logic [SIZES_W-1:0] sizes_m;
	logic [CNT_W-1:0]   tally_m [NENTRIES];
	int unsigned        expired_m;
	logic [GROUP_W-1:0] dump_grp_m [NDUMP];
	logic [INST_W-1:0]  dump_inst_m [NDUMP];

	outcome_t  outcome_q [$];
	plan_row_t directed_plan [$];
	int        bad_count = 0;
	int        idle_pct = 0;
	int        cycle_cnt = 0;
	outcome_t  got_res;
	outcome_t  want_res;

	fault_counter_table_with_expiry_dump u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.group        (group),
		.instance_req (instance_req),
		.dump_slot    (dump_slot),
		.done         (done),
		.status       (status),
		.expired_count(expired_count),
		.dump_group   (dump_group),
		.dump_instance(dump_instance),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == RUN_LIMIT) begin
			$display("fault_counter_table_with_expiry_dump test failed");
			$finish;
		end
	end

	function automatic void flag_mismatch(input string msg);
		bad_count++;
		if (bad_count <= 10) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
	endfunction

	function automatic int unsigned group_size(input int g);
		if (g >= NGROUPS) begin
			return 0;
		end
		return sizes_m[g*SIZE_W +: SIZE_W];
	endfunction

	function automatic int unsigned group_base(input int g);
		int unsigned sum;
		sum = 0;
		for (int i = 0; i < g && i < NGROUPS; i++) begin
			sum += group_size(i);
		end
		return sum;
	endfunction

	function automatic int unsigned reachable_entries();
		int unsigned lim;
		lim = group_base(NGROUPS);
		return (lim > NENTRIES) ? NENTRIES : lim;
	endfunction

	// Flat slot of a pair; NENTRIES marks a bad pair
	function automatic int unsigned flat_of(input int g, input int unsigned inst);
		int unsigned idx;
		if (g >= NGROUPS || inst >= group_size(g)) begin
			return NENTRIES;
		end
		idx = group_base(g) + inst;
		return (idx < NENTRIES) ? idx : NENTRIES;
	endfunction

	// Flat slot back to {group, instance}
	function automatic logic [DUMP_W-1:0] decode_flat(input int unsigned idx);
		int g;
		int unsigned rem;
		rem = idx;
		for (g = 0; g < NGROUPS; g++) begin
			if (rem < group_size(g)) begin
				break;
			end
			rem -= group_size(g);
		end
		return {GROUP_W'(g), INST_W'(rem)};
	endfunction

	// Applies one request to the local state and returns its outcome
	function automatic outcome_t run_fault_op(input request_t r);
		outcome_t o;
		int unsigned idx;
		int unsigned fill;
		logic [DUMP_W-1:0] gi;
		o = '0;
		o.st = ST_OK;
		case (r.md)
			MODE_SET, MODE_CLR: begin
				idx = flat_of(int'(r.grp), r.inst);
				if (idx >= NENTRIES) begin
					o.st = ST_INVALID;
				end else if (r.md == MODE_SET) begin
					if (tally_m[idx] != '1) begin
						tally_m[idx] = tally_m[idx] + 1'b1;
					end
				end else begin
					tally_m[idx] = '0;
				end
			end
			MODE_SCAN: begin
				// sticky: only runs while nothing is recorded
				if (expired_m == 0) begin
					for (int i = 0; i < reachable_entries(); i++) begin
						if (tally_m[i] >= thr_m) begin
							if (expired_m < NDUMP) begin
								gi = decode_flat(i);
								dump_grp_m[expired_m] = gi[DUMP_W-1 -: GROUP_W];
								dump_inst_m[expired_m] = gi[INST_W-1:0];
							end
							expired_m++;
						end
					end
				end
			end
			default: begin
				fill = (expired_m < NDUMP) ? expired_m : NDUMP;
				if (r.slot < fill) begin
					o.grp = dump_grp_m[r.slot];
					o.inst = dump_inst_m[r.slot];
				end else begin
					o.st = ST_EMPTY;
				end
			end
		endcase
		o.cnt = TOTAL_W'(expired_m);
		return o;
	endfunction

	function automatic request_t random_request(input int set_w, input int clr_w,
			input int scan_w);
		request_t r;
		int pick;
		int unsigned lim;
		logic [DUMP_W-1:0] gi;
		r.grp = GROUP_W'($urandom_range(0, 15));
		r.inst = INST_W'($urandom_range(0, 31));
		r.slot = SLOT_W'($urandom_range(0, 31));
		pick = $urandom_range(0, 99);
		if (pick < set_w) begin
			r.md = MODE_SET;
		end else if (pick < set_w + clr_w) begin
			r.md = MODE_CLR;
		end else if (pick < set_w + clr_w + scan_w) begin
			r.md = MODE_SCAN;
		end else begin
			r.md = MODE_READ;
		end
		// mostly reachable pairs, the rest raw noise
		lim = reachable_entries();
		if ((r.md == MODE_SET || r.md == MODE_CLR) && lim != 0
				&& $urandom_range(0, 99) < 80) begin
			gi = decode_flat($urandom_range(0, lim - 1));
			r.grp = gi[DUMP_W-1 -: GROUP_W];
			r.inst = gi[INST_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [APB_DW-1:0] random_sizes(input int hi, input int zero_pct);
		logic [APB_DW-1:0] v;
		v = '0;
		for (int g = 0; g < NGROUPS; g++) begin
			if ($urandom_range(0, 99) >= zero_pct) begin
				v[g*SIZE_W +: SIZE_W] = SIZE_W'($urandom_range(0, hi));
			end
		end
		return v;
	endfunction

	function automatic plan_row_t op_row(input mode_t m, input int g, input int i,
			input int s, input bit typed, input status_t st);
		plan_row_t row;
		row.kind = STEP_REQ;
		row.req = '{md: m, grp: GROUP_W'(g), inst: INST_W'(i), slot: SLOT_W'(s)};
		row.value = '0;
		row.typed = typed;
		row.want = '0;
		row.want.st = st;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(input step_kind_t k, input logic [APB_DW-1:0] v);
		plan_row_t row;
		row.kind = k;
		row.req = '0;
		row.value = v;
		row.typed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	// Result checker
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			got_res = {status, expired_count, dump_group, dump_instance};
			if (outcome_q.size() == 0) begin
				flag_mismatch($sformatf("result with no request pending: st %0d cnt %0d g %0d i %0d",
					got_res.st, got_res.cnt, got_res.grp, got_res.inst));
			end else begin
				want_res = outcome_q.pop_front();
				if (got_res.st !== want_res.st || got_res.cnt !== want_res.cnt
						|| got_res.grp !== want_res.grp || got_res.inst !== want_res.inst) begin
					flag_mismatch($sformatf("exp st %0d cnt %0d g %0d i %0d, got st %0d cnt %0d g %0d i %0d",
						want_res.st, want_res.cnt, want_res.grp, want_res.inst,
						got_res.st, got_res.cnt, got_res.grp, got_res.inst));
				end
			end
		end
	end

	// One request; optional idle burst first
	task automatic issue(input request_t r, input bit typed, input outcome_t want);
		outcome_t pred;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		mode <= r.md;
		group <= r.grp;
		instance_req <= r.inst;
		dump_slot <= r.slot;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		pred = run_fault_op(r);
		outcome_q.push_back(typed ? want : pred);
	endtask

	// Stop requesting and wait for every outstanding result
	task automatic settle();
		start <= 1'b0;
		while (outcome_q.size() != 0 || busy !== 1'b0) @(posedge clk);
	endtask

	// APB write, read back, then wait out any rebuild
	task automatic program_register(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] mask;
		mask = (addr == THR_ADDR) ? APB_DW'(8'hFF) : SIZES_FULL;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value & mask;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		if (addr == THR_ADDR) begin
			thr_m = value[CNT_W-1:0];
		end else begin
			sizes_m = value[SIZES_W-1:0];
		end
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		if ((prdata & mask) !== (value & mask)) begin
			flag_mismatch($sformatf("readback of 0x%0h: exp 0x%0h got 0x%0h",
				addr, value & mask, prdata & mask));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic run_random(input int n, input int set_w, input int clr_w, input int scan_w);
		for (int k = 0; k < n; k++) begin
			issue(random_request(set_w, clr_w, scan_w), 1'b0, '0);
		end
	endtask

	// Main sequence
	initial begin
		request_t hammer;
		logic [DUMP_W-1:0] gi;

		thr_m = THR_RESET;
		sizes_m = '0;
		expired_m = 0;
		for (int i = 0; i < NENTRIES; i++) begin
			tally_m[i] = '0;
		end

		// reset state: nothing configured, every pair bad, dump empty
		directed_plan.push_back(op_row(MODE_SET, 0, 0, 31, 1, ST_INVALID));
		directed_plan.push_back(op_row(MODE_CLR, 15, 31, 31, 1, ST_INVALID));
		directed_plan.push_back(op_row(MODE_SCAN, 15, 31, 31, 1, ST_OK));
		directed_plan.push_back(op_row(MODE_READ, 0, 0, 0, 1, ST_EMPTY));
		directed_plan.push_back(op_row(MODE_READ, 15, 31, 31, 1, ST_EMPTY));
		// threshold zero on an empty table still finds nothing
		directed_plan.push_back(cfg_row(STEP_THR, 64'd0));
		directed_plan.push_back(op_row(MODE_SCAN, 0, 0, 0, 1, ST_OK));
		directed_plan.push_back(cfg_row(STEP_THR, 64'd255));
		// every group full: the table is truncated inside group 2
		directed_plan.push_back(cfg_row(STEP_SIZES, SIZES_FULL));
		directed_plan.push_back(op_row(MODE_SET, 0, 0, 31, 0, ST_OK));
		directed_plan.push_back(op_row(MODE_SET, 0, 30, 0, 0, ST_OK));
		directed_plan.push_back(op_row(MODE_SET, 2, 1, 17, 1, ST_OK));
		directed_plan.push_back(op_row(MODE_SET, 2, 2, 0, 1, ST_INVALID));
		directed_plan.push_back(op_row(MODE_SET, 1, 31, 0, 1, ST_INVALID));
		directed_plan.push_back(op_row(MODE_SET, 10, 0, 0, 1, ST_INVALID));
		directed_plan.push_back(op_row(MODE_SET, 11, 0, 0, 1, ST_INVALID));
		directed_plan.push_back(op_row(MODE_CLR, 0, 0, 0, 0, ST_OK));
		directed_plan.push_back(op_row(MODE_SCAN, 0, 0, 0, 0, ST_OK));
		directed_plan.push_back(op_row(MODE_READ, 10, 20, 5, 1, ST_EMPTY));
		// sizes that fill the table exactly
		directed_plan.push_back(cfg_row(STEP_SIZES, SIZES_EXACT));
		directed_plan.push_back(op_row(MODE_SET, 2, 1, 31, 1, ST_OK));
		directed_plan.push_back(op_row(MODE_CLR, 3, 0, 0, 1, ST_INVALID));
		directed_plan.push_back(op_row(MODE_SET, 15, 31, 0, 1, ST_INVALID));
		directed_plan.push_back(op_row(MODE_READ, 15, 31, 16, 1, ST_EMPTY));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		idle_pct = 25;
		foreach (directed_plan[k]) begin
			case (directed_plan[k].kind)
				STEP_REQ: begin
					issue(directed_plan[k].req, directed_plan[k].typed, directed_plan[k].want);
				end
				STEP_THR: begin
					settle();
					program_register(THR_ADDR, directed_plan[k].value);
				end
				default: begin
					settle();
					program_register(SIZES_ADDR, directed_plan[k].value);
				end
			endcase
		end

		// random phases; thresholds stay out of reach so scans find nothing
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			case (ph)
				0: begin
					program_register(SIZES_ADDR, SIZES_FULL);
					program_register(THR_ADDR, 64'd255);
					idle_pct = 30;
				end
				1: begin
					program_register(SIZES_ADDR, random_sizes(31, 25));
					program_register(THR_ADDR, 64'd254);
					idle_pct = 0;
				end
				2: begin
					program_register(SIZES_ADDR, random_sizes(8, 10));
					program_register(THR_ADDR, 64'd200);
					idle_pct = 40;
				end
				default: begin
					program_register(SIZES_ADDR, {$urandom, $urandom});
					program_register(THR_ADDR, 64'd255);
					idle_pct = 20;
				end
			endcase
			run_random(275, 50, 20, 10);
		end

		// last part: no idling, one saturated counter, then the sticky scan
		settle();
		idle_pct = 0;
		program_register(SIZES_ADDR, random_sizes(31, 15) | 64'd1);
		program_register(THR_ADDR, 64'd5);
		gi = decode_flat($urandom_range(0, reachable_entries() - 1));
		hammer = '{md: MODE_SET, grp: gi[DUMP_W-1 -: GROUP_W], inst: gi[INST_W-1:0],
			slot: SLOT_W'($urandom_range(0, 31))};
		// past 255 a wrapped counter would fall below the threshold
		repeat (260) issue(hammer, 1'b0, '0);
		issue('{md: MODE_SCAN, grp: '0, inst: '0, slot: '0}, 1'b0, '0);
		run_random(300, 20, 15, 15);

		settle();
		repeat (DRAIN) @(posedge clk);
		if (bad_count == 0 && outcome_q.size() == 0) begin
			$display("fault_counter_table_with_expiry_dump test passed");
		end else begin
			$display("fault_counter_table_with_expiry_dump test failed");
		end
		$finish;
	end

endmodule
